// ===== rtl/core/dots_pkg.sv =====
// Shared types and constants for the DHCP option tag search block.
package dots_pkg;

  // Largest options block the search covers, in bytes
  localparam int MAX_BLOCK_BYTES = 1024;

  // Byte positions must hold the block size itself
  localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int TAG_W    = 16;
  localparam int BLEN_W   = 11;
  localparam int OFF_W    = 10;
  localparam int OLEN_W   = 9;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Packed widths of the stream groups, rounded up to whole bytes
  localparam int OUT_DATA_BITS = OFF_W + OLEN_W + 1 + OFF_W;
  localparam int OUT_DATA_W = ((OUT_DATA_BITS + 7) / 8) * 8;

  // One-byte option tags
  localparam logic [BYTE_W-1:0] TAG_PAD = 8'h00;
  localparam logic [BYTE_W-1:0] TAG_END = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_TAG   = 1'b0,
    REG_BLOCK_LENGTH = 1'b1
  } cfg_reg_t;

  // Search outcome codes
  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND       = 3'd0,
    ST_PAD_REFUSED = 3'd1,
    ST_END_MARK    = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_EXHAUSTED   = 3'd4
  } status_t;

endpackage

// ===== rtl/core/dhcp_option_tag_search.sv =====
// Streaming search of a DHCP options block for one configured option tag.
//
// Bytes of an options block enter on the s_ group, one beat per byte, with
// s_tuser set on the first byte of a block. One beat is taken every clock; the
// parse state (phase, position, current option, encapsulation region) updates
// in the same cycle a byte is accepted, and the single result of a block
// leaves through one output register on the m_ group on the cycle after the
// byte that decides the search. The input stalls only while that output
// register holds a beat that the sink has not taken. search_tag is read live
// on each byte; block_length is sampled on the first byte of a block and
// limited to MAX_BLOCK_BYTES. A nonzero high byte of search_tag names an
// encapsulating option whose payload is then searched for the low byte.
module dhcp_option_tag_search (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dots_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dots_pkg::CFG_DATA_W-1:0]    cfg_data,
  // byte input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic [0:0]                         s_tuser,   // [0] block_start
  // result output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [9:0] option_offset, [18:10] option_length, [19] encap_found,
  // [29:20] encapsulator_offset, [31:30] zero
  output logic [dots_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [dots_pkg::STATUS_W-1:0]      m_tuser    // [2:0] status
);
  import dots_pkg::*;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  // configuration registers
  logic [TAG_W-1:0]  search_tag;
  logic [BLEN_W-1:0] block_length;

  // parse state
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [POS_W-1:0]   opt_start, opt_start_next;
  logic [BYTE_W-1:0]  cur_tag, cur_tag_next;
  logic [BYTE_W-1:0]  bytes_left, bytes_left_next;
  logic [POS_W-1:0]   region_end, region_end_next;
  logic               in_encap, in_encap_next;
  logic [OFF_W-1:0]   encap_pos, encap_pos_next;
  logic               finished, finished_next;

  // per-beat decision
  logic               in_fire;
  logic               res_fire;
  status_t            res_status;
  logic [OFF_W-1:0]   res_offset;
  logic [OLEN_W-1:0]  res_length;
  logic               done;
  logic               sought_ok;
  logic [POS_W-1:0]   start_region;
  logic [OLEN_W-1:0]  total;
  logic [BYTE_W-1:0]  data_byte;
  logic               block_start;

  assign data_byte   = s_tdata;
  assign block_start = s_tuser[0];
  assign s_tready    = !m_tvalid || m_tready;
  assign in_fire     = s_tvalid && s_tready;
  assign total       = OLEN_W'(data_byte) + OLEN_W'(2);

  // Clamp the sampled block length to the supported size
  assign start_region = (int'(block_length) < MAX_BLOCK_BYTES) ?
                        POS_W'(block_length) : POS_W'(MAX_BLOCK_BYTES);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      search_tag   <= '0;
      block_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEARCH_TAG:   search_tag   <= cfg_data[TAG_W-1:0];
        REG_BLOCK_LENGTH: block_length <= cfg_data[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Parse one byte: next state and the result it decides, if any
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    opt_start_next     = opt_start;
    cur_tag_next       = cur_tag;
    bytes_left_next    = bytes_left;
    region_end_next    = region_end;
    in_encap_next      = in_encap;
    encap_pos_next     = encap_pos;
    finished_next      = finished;
    res_fire           = 1'b0;
    res_status         = ST_FOUND;
    res_offset         = '0;
    res_length         = '0;
    done               = 1'b0;
    sought_ok          = 1'b0;

    // Restart on the first byte of a block
    if (block_start) begin
      finished_next      = 1'b0;
      phase_next         = PH_TAG;
      byte_position_next = '0;
      opt_start_next     = '0;
      cur_tag_next       = '0;
      bytes_left_next    = '0;
      in_encap_next      = 1'b0;
      encap_pos_next     = '0;
      region_end_next    = start_region;
      if (search_tag == '0) begin
        res_fire   = 1'b1;
        res_status = ST_PAD_REFUSED;
        done       = 1'b1;
      end else if (start_region == '0) begin
        res_fire   = 1'b1;
        res_status = ST_EXHAUSTED;
        done       = 1'b1;
      end
    end

    if (!done && !finished_next) begin
      // The low tag byte matches only inside the encapsulator or when no encapsulator is named
      sought_ok = in_encap_next || (search_tag[15:8] == '0);
      byte_position_next = byte_position_next + POS_W'(1);
      unique case (phase_next)
        PH_LEN: begin
          if (int'(total) > int'(region_end_next) - int'(opt_start_next)) begin
            res_fire   = 1'b1;
            res_status = ST_OVERRUN;
            done       = 1'b1;
          end else if (sought_ok && cur_tag_next == search_tag[7:0]) begin
            res_fire   = 1'b1;
            res_status = ST_FOUND;
            res_offset = OFF_W'(opt_start_next);
            res_length = total;
            done       = 1'b1;
          end else if (!in_encap_next && search_tag[15:8] != '0 &&
                       cur_tag_next == search_tag[15:8]) begin
            // Enter the encapsulator: its payload becomes the region
            in_encap_next   = 1'b1;
            encap_pos_next  = OFF_W'(opt_start_next);
            region_end_next = POS_W'(int'(byte_position_next) + int'(data_byte));
            phase_next      = PH_TAG;
            done            = 1'b1;
            if (data_byte == '0) begin
              res_fire   = 1'b1;
              res_status = ST_EXHAUSTED;
            end
          end else begin
            bytes_left_next = data_byte;
            phase_next      = (data_byte != '0) ? PH_SKIP : PH_TAG;
          end
        end
        PH_SKIP: begin
          bytes_left_next = bytes_left_next - BYTE_W'(1);
          if (bytes_left_next == '0) begin
            phase_next = PH_TAG;
          end
        end
        default: begin
          phase_next     = PH_TAG;
          opt_start_next = byte_position;
          if (block_start) begin
            opt_start_next = '0;
          end
          cur_tag_next = data_byte;
          if (data_byte == TAG_END) begin
            res_fire = 1'b1;
            done     = 1'b1;
            if (sought_ok && search_tag[7:0] == TAG_END) begin
              res_status = ST_FOUND;
              res_offset = OFF_W'(opt_start_next);
              res_length = OLEN_W'(1);
            end else begin
              res_status = ST_END_MARK;
            end
          end else if (data_byte == TAG_PAD) begin
            if (sought_ok && search_tag[7:0] == TAG_PAD) begin
              res_fire   = 1'b1;
              res_status = ST_FOUND;
              res_offset = OFF_W'(opt_start_next);
              res_length = OLEN_W'(1);
              done       = 1'b1;
            end
          end else if (int'(region_end_next) - int'(opt_start_next) < 2) begin
            res_fire   = 1'b1;
            res_status = ST_OVERRUN;
            done       = 1'b1;
          end else begin
            phase_next = PH_LEN;
            done       = 1'b1;
          end
        end
      endcase

      // Region used up at an option boundary
      if (!done && phase_next == PH_TAG &&
          int'(byte_position_next) >= int'(region_end_next)) begin
        res_fire   = 1'b1;
        res_status = ST_EXHAUSTED;
      end
    end

    if (res_fire) begin
      finished_next = 1'b1;
    end
  end

  // Hold parse state; advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      byte_position <= '0;
      opt_start     <= '0;
      cur_tag       <= '0;
      bytes_left    <= '0;
      region_end    <= '0;
      in_encap      <= 1'b0;
      encap_pos     <= '0;
      finished      <= 1'b1;
    end else if (in_fire) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      opt_start     <= opt_start_next;
      cur_tag       <= cur_tag_next;
      bytes_left    <= bytes_left_next;
      region_end    <= region_end_next;
      in_encap      <= in_encap_next;
      encap_pos     <= encap_pos_next;
      finished      <= finished_next;
    end
  end

  // Output register: load a decided result, drop it once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && res_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      m_tuser <= res_status;
      m_tdata <= OUT_DATA_W'({(in_encap_next ? encap_pos_next : OFF_W'(0)),
                              in_encap_next, res_length, res_offset});
    end
  end

  // A decided result always leaves the search finished
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_fire) |=> finished)
    else $error("search not finished after a result");

  // Only a match carries an offset or a length
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_FOUND) |-> (m_tdata[18:0] == '0))
    else $error("offset or length set on a non-match result");

  // A match always has a nonzero option length
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FOUND) |-> (m_tdata[18:10] != '0))
    else $error("match with zero option length");

  // Encapsulator offset is zero unless the encapsulator was entered
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[19]) |-> (m_tdata[29:20] == '0))
    else $error("encapsulator offset without encapsulator");

  // Parse position never runs past the search region while searching
  assert property (@(posedge clk) disable iff (rst)
    !finished |-> (int'(byte_position) < int'(region_end)))
    else $error("byte position past region end during search");

endmodule
